[rtl/core/escape_sequence_parser_macros.svh]
// Assertion macros for the escape sequence parser checker.
// Used by esp_checker; relies on i_clk and i_rst_n in the including scope.
`ifndef ESCAPE_SEQUENCE_PARSER_MACROS_SVH
`define ESCAPE_SEQUENCE_PARSER_MACROS_SVH

// same-cycle implication
`define ESP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("esp check failed");

// next-cycle implication
`define ESP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("esp check failed");

`endif

[rtl/core/esp_pkg.sv]
// Shared types, codes and the escape rule trie ROM for the escape sequence parser.
// No dependencies.
package esp_pkg;

    localparam int MAX_PARAMS_DEF = 16;
    localparam int OUT_LIMIT      = 16;

    localparam logic [8:0] TOK_NUM  = 9'd256;
    localparam logic [8:0] TOK_LIST = 9'd257;
    localparam logic [8:0] TOK_STR  = 9'd258;

    localparam logic [7:0] CH_BEL  = 8'h07;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_COLN = 8'h3A;

    localparam logic [1:0] EV_STR    = 2'd0;
    localparam logic [1:0] EV_ACCEPT = 2'd1;
    localparam logic [1:0] EV_REFEED = 2'd2;
    localparam logic [1:0] EV_ERROR  = 2'd3;

    typedef enum logic [2:0] {
        LD_NONE, LD_ESC, LD_BYTE, LD_ERR, LD_ACC, LD_PAR
    } t_ld;

    typedef struct packed {
        logic       take;   // input transfer this cycle
        logic       rd;     // parameter RAM read
        t_ld        ld;     // output register load
        logic       last;
        logic [3:0] idx;
    } t_cmd;

    typedef struct packed {
        logic       esc;      // held ESC released as a string byte
        logic       sbyte;    // string byte
        logic       acc;      // accept
        logic       err;      // error
        logic [4:0] burst_n;  // parameter results of the accept
    } t_status;

    typedef struct packed {
        logic       hit;
        logic       fin;
        logic [6:0] target;   // next node, or rule number when fin
    } t_edge;

    function automatic t_edge mk_fin(input logic [6:0] id);
        t_edge e;
        e = '{hit: 1'b1, fin: 1'b1, target: id};
        return e;
    endfunction

    function automatic t_edge mk_go(input logic [6:0] node);
        t_edge e;
        e = '{hit: 1'b1, fin: 1'b0, target: node};
        return e;
    endfunction

    // final bytes shared by the CSI nodes with and without a number
    function automatic t_edge csi_final(input logic [8:0] tok);
        t_edge e;
        e = '0;
        case (tok) inside
            [9'h041:9'h048]: e = mk_fin(7'(tok - 9'h040));
            9'h06D: e = mk_fin(7'd0);
            9'h04A: e = mk_fin(7'd13);
            9'h04B: e = mk_fin(7'd14);
            9'h04C: e = mk_fin(7'd18);
            9'h04D: e = mk_fin(7'd19);
            9'h040: e = mk_fin(7'd20);
            9'h050: e = mk_fin(7'd21);
            9'h058: e = mk_fin(7'd22);
            9'h053: e = mk_fin(7'd23);
            9'h054: e = mk_fin(7'd24);
            9'h064: e = mk_fin(7'd25);
            9'h065: e = mk_fin(7'd26);
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic t_edge trie_lookup(input logic [6:0] st, input logic [8:0] tok);
        t_edge e;
        e = '0;
        case (st)
            7'd0: begin
                case (tok)
                    9'h05B:  e = mk_go(7'd1);
                    9'h028:  e = mk_go(7'd7);
                    TOK_NUM: e = mk_fin(7'd15);
                    9'h04D:  e = mk_fin(7'd16);
                    9'h05D:  e = mk_go(7'd11);
                    9'h050:  e = mk_go(7'd14);
                    default: e = '0;
                endcase
            end
            7'd1: begin
                case (tok)
                    TOK_LIST: e = mk_go(7'd2);
                    TOK_NUM:  e = mk_go(7'd3);
                    9'h03F:   e = mk_go(7'd4);
                    default:  e = csi_final(tok);
                endcase
            end
            7'd2: begin
                case (tok)
                    9'h06D:  e = mk_fin(7'd0);
                    9'h048:  e = mk_fin(7'd12);
                    9'h066:  e = mk_fin(7'd12);
                    9'h072:  e = mk_fin(7'd17);
                    default: e = '0;
                endcase
            end
            7'd3: begin
                case (tok)
                    9'h068:  e = mk_fin(7'd27);
                    9'h06C:  e = mk_fin(7'd28);
                    9'h020:  e = mk_go(7'd18);
                    default: e = csi_final(tok);
                endcase
            end
            7'd4: begin
                case (tok)
                    TOK_LIST: e = mk_go(7'd5);
                    TOK_NUM:  e = mk_go(7'd6);
                    default:  e = '0;
                endcase
            end
            7'd5, 7'd6: begin
                case (tok)
                    9'h068:  e = mk_fin(7'd9);
                    9'h06C:  e = mk_fin(7'd10);
                    default: e = '0;
                endcase
            end
            7'd7: begin
                case (tok) inside
                    9'h022: e = mk_go(7'd8);
                    9'h025: e = mk_go(7'd9);
                    9'h026: e = mk_go(7'd10);
                    9'h041, 9'h042, 9'h043, 9'h035, 9'h048, 9'h037, 9'h04B, 9'h051,
                    9'h039, 9'h052, 9'h066, 9'h059, 9'h05A, 9'h034, 9'h03D, 9'h060,
                    9'h045, 9'h030, 9'h03C, 9'h03E, 9'h049, 9'h04A:
                        e = mk_fin(7'd11);
                    default: e = '0;
                endcase
            end
            7'd8: begin
                case (tok) inside
                    9'h03E, 9'h034, 9'h03F: e = mk_fin(7'd11);
                    default: e = '0;
                endcase
            end
            7'd9: begin
                case (tok) inside
                    9'h030, 9'h035, 9'h033, 9'h032, 9'h036, 9'h03D: e = mk_fin(7'd11);
                    default: e = '0;
                endcase
            end
            7'd10: begin
                case (tok) inside
                    9'h034, 9'h035: e = mk_fin(7'd11);
                    default: e = '0;
                endcase
            end
            7'd11: e = (tok == TOK_NUM) ? mk_go(7'd12) : '0;
            7'd12: e = (tok == 9'h03B) ? mk_go(7'd13) : '0;
            7'd13: e = (tok == TOK_STR) ? mk_fin(7'd29) : '0;
            7'd14: e = (tok == 9'h02B) ? mk_go(7'd15) : '0;
            7'd15: begin
                case (tok)
                    9'h051:  e = mk_go(7'd16);
                    9'h071:  e = mk_go(7'd17);
                    default: e = '0;
                endcase
            end
            7'd16: e = (tok == TOK_STR) ? mk_fin(7'd30) : '0;
            7'd17: e = (tok == TOK_STR) ? mk_fin(7'd31) : '0;
            7'd18: e = (tok == 9'h071) ? mk_fin(7'd32) : '0;
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

[rtl/core/escape_sequence_parser.sv]
// Escape sequence parser top level: controller plus datapath on stream ports.
// Depends on esp_pkg, esp_ctrl, esp_dp (and esp_ram below it).
//
// Feed the bytes that follow ESC, one per input transfer. Each byte is
// tokenized and walked through a fixed trie of escape rules; it gives no
// result, string bytes, one error, or an accept burst of one result per kept
// parameter (tlast on the final one). Items are handled one at a time: the
// input is taken in one cycle and the plan latched in the next, then each
// result is loaded into the output register (a parameter's value comes out
// of the registered parameter RAM first) and held through any output stall.
// A byte with no result frees the input after the start and next states; a
// byte with results frees it in the cycle after its last result transfers.
module escape_sequence_parser
    import esp_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] rule_id, [13:6] final_char, [21:14] middle_char, [25:22] param_index,
    // [41:26] param_value, [46:42] param_count, [47] param_overflow, [55:48] string_byte
    output logic [55:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] event_res
    output logic        m_axis_tlast
);
    t_cmd        w_cmd;
    t_status     w_status;
    logic [5:0]  w_rule;
    logic [7:0]  w_fin, w_mid, w_sb;
    logic [3:0]  w_idx;
    logic [15:0] w_val;
    logic [4:0]  w_cnt;
    logic        w_ovf;

    esp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .o_in_tready  (s_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    esp_dp #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_byte           (s_axis_tdata),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_event_res      (m_axis_tuser),
        .o_rule_id        (w_rule),
        .o_final_char     (w_fin),
        .o_middle_char    (w_mid),
        .o_param_index    (w_idx),
        .o_param_value    (w_val),
        .o_param_count    (w_cnt),
        .o_param_overflow (w_ovf),
        .o_string_byte    (w_sb),
        .o_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {w_sb, w_ovf, w_cnt, w_val, w_idx, w_mid, w_fin, w_rule};
endmodule

[rtl/core/esp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module esp_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/esp_ctrl.sv]
// Controller: takes one byte at a time and sequences its results onto the output.
// Depends on esp_pkg.
module esp_ctrl
    import esp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_tvalid,
    output logic    o_in_tready,
    output logic    o_out_tvalid,
    input  logic    i_out_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_START, S_NEXT, S_RDWAIT, S_HOLD} t_state;

    t_state     r_state, n_state;
    logic       r_need_esc, n_need_esc;
    logic       r_need_byte, n_need_byte;
    logic       r_need_acc, n_need_acc;
    logic       r_need_err, n_need_err;
    logic [4:0] r_cnt, n_cnt;
    logic [4:0] r_idx, n_idx;
    logic       r_last, n_last;
    logic [4:0] w_idx_inc;

    assign w_idx_inc = r_idx + 5'd1;

    always_comb begin
        n_state     = r_state;
        n_need_esc  = r_need_esc;
        n_need_byte = r_need_byte;
        n_need_acc  = r_need_acc;
        n_need_err  = r_need_err;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_last      = r_last;
        o_cmd       = '0;
        o_cmd.ld    = LD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_tvalid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_need_esc  = i_status.esc;
                n_need_byte = i_status.sbyte;
                n_need_acc  = i_status.acc;
                n_need_err  = i_status.err;
                n_cnt       = i_status.burst_n;
                n_idx       = '0;
                n_state     = S_NEXT;
            end
            S_NEXT: begin
                if (r_need_esc) begin
                    o_cmd.ld   = LD_ESC;
                    o_cmd.last = !(r_need_byte || r_need_acc || r_need_err);
                    n_last     = o_cmd.last;
                    n_need_esc = 1'b0;
                    n_state    = S_HOLD;
                end else if (r_need_byte) begin
                    o_cmd.ld   = LD_BYTE;
                    o_cmd.last = 1'b1;
                    n_last     = 1'b1;
                    n_state    = S_HOLD;
                end else if (r_need_err) begin
                    o_cmd.ld   = LD_ERR;
                    o_cmd.last = 1'b1;
                    n_last     = 1'b1;
                    n_state    = S_HOLD;
                end else if (r_need_acc && r_cnt == 5'd0) begin
                    o_cmd.ld   = LD_ACC;
                    o_cmd.last = 1'b1;
                    n_last     = 1'b1;
                    n_state    = S_HOLD;
                end else if (r_need_acc) begin
                    o_cmd.rd  = 1'b1;
                    o_cmd.idx = r_idx[3:0];
                    n_state   = S_RDWAIT;
                end else begin
                    n_state = S_IDLE;   // byte gave no result
                end
            end
            S_RDWAIT: begin
                o_cmd.ld   = LD_PAR;
                o_cmd.idx  = r_idx[3:0];
                o_cmd.last = (w_idx_inc == r_cnt);
                n_last     = o_cmd.last;
                n_idx      = w_idx_inc;
                n_state    = S_HOLD;
            end
            S_HOLD: begin
                if (i_out_tready) begin
                    n_state = r_last ? S_IDLE : S_NEXT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_need_esc   <= 1'b0;
            r_need_byte  <= 1'b0;
            r_need_acc   <= 1'b0;
            r_need_err   <= 1'b0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_last       <= 1'b0;
            o_in_tready  <= 1'b1;
            o_out_tvalid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_need_esc   <= n_need_esc;
            r_need_byte  <= n_need_byte;
            r_need_acc   <= n_need_acc;
            r_need_err   <= n_need_err;
            r_cnt        <= n_cnt;
            r_idx        <= n_idx;
            r_last       <= n_last;
            o_in_tready  <= (n_state == S_IDLE);
            o_out_tvalid <= (n_state == S_HOLD);
        end
    end
endmodule

[rtl/core/esp_dp.sv]
// Datapath: tokenizer, trie walk, number accumulator, parameter RAM and output register.
// Depends on esp_pkg and esp_ram.
module esp_dp
    import esp_pkg::*;
#(
    parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_byte,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [1:0]  o_event_res,
    output logic [5:0]  o_rule_id,
    output logic [7:0]  o_final_char,
    output logic [7:0]  o_middle_char,
    output logic [3:0]  o_param_index,
    output logic [15:0] o_param_value,
    output logic [4:0]  o_param_count,
    output logic        o_param_overflow,
    output logic [7:0]  o_string_byte,
    output logic        o_last
);
    localparam int FW = $clog2(MAX_PARAMS + 1);
    localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    typedef enum logic [1:0] {MODE_NONE, MODE_NUM, MODE_LIST, MODE_STR} t_mode;

    // sequence state
    logic [6:0]    r_trie, n_trie;
    t_mode         r_mode, n_mode;
    logic [15:0]   r_acc, n_acc;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_ovf, n_ovf;
    logic          r_esc, n_esc;
    logic [7:0]    r_h0, n_h0;
    logic [7:0]    r_h1, n_h1;

    // plan of the accepted byte
    t_status       r_st, n_st;
    logic [1:0]    r_p_ev, n_p_ev;
    logic [6:0]    r_p_rule, n_p_rule;
    logic [7:0]    r_p_fin, n_p_fin;
    logic [7:0]    r_p_mid, n_p_mid;
    logic [4:0]    r_p_count, n_p_count;
    logic          r_p_ovf, n_p_ovf;
    logic [7:0]    r_p_byte;

    // output register
    logic [1:0]    r_o_ev;
    logic [5:0]    r_o_rule;
    logic [7:0]    r_o_fin, r_o_mid, r_o_sb;
    logic [3:0]    r_o_idx;
    logic [15:0]   r_o_val;
    logic [4:0]    r_o_cnt;
    logic          r_o_ovf, r_o_last;

    logic          w_digit, w_sep, w_str_path, w_num_path, w_esc_in;
    logic [3:0]    w_d;
    logic [19:0]   w_mul;
    logic [15:0]   w_sat;
    logic [8:0]    w_tok1;
    t_edge         w_es, w_el, w_e1, w_e2;
    logic          w_we;
    logic [15:0]   w_rdata;
    logic [6:0]    w_fill_ext;
    logic [6:0]    w_ridx_ext;

    logic          v_push, v_tk, v_tk_char;
    t_edge         v_edge;
    logic [1:0]    v_ev;
    logic [FW-1:0] v_fill;
    logic          v_ovf;
    logic [7:0]    v_h0, v_h1;
    logic [6:0]    v_fill7, v_cap;

    assign w_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign w_sep   = (i_byte == CH_SEMI) || (i_byte == CH_COLN);
    assign w_d     = i_byte[3:0];
    assign w_mul   = 20'({r_acc, 3'b000}) + 20'({r_acc, 1'b0}) + 20'(w_d);
    assign w_sat   = (w_mul > 20'd65535) ? 16'hFFFF : w_mul[15:0];

    assign w_es       = trie_lookup(r_trie, TOK_STR);
    assign w_el       = trie_lookup(r_trie, TOK_LIST);
    assign w_str_path = (r_mode == MODE_STR) || (r_mode == MODE_NONE && w_es.hit);
    assign w_num_path = (r_mode == MODE_NUM) || (r_mode == MODE_LIST);
    assign w_esc_in   = (r_mode == MODE_STR) && r_esc;
    assign w_tok1     = w_str_path ? TOK_STR :
                        w_num_path ? ((r_mode == MODE_LIST) ? TOK_LIST : TOK_NUM) :
                        {1'b0, i_byte};
    assign w_e1       = trie_lookup(r_trie, w_tok1);
    // after a number token the ending byte is looked up again from the new node
    assign w_e2       = trie_lookup(w_e1.target, {1'b0, i_byte});

    always_comb begin
        n_trie    = r_trie;
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_esc     = r_esc;
        n_st      = '0;
        n_p_ev    = EV_ACCEPT;
        n_p_rule  = '0;
        n_p_fin   = '0;
        n_p_mid   = '0;
        n_p_count = '0;
        n_p_ovf   = 1'b0;
        v_push    = 1'b0;
        v_tk      = 1'b0;
        v_tk_char = 1'b0;
        v_edge    = w_e1;
        v_ev      = EV_ACCEPT;

        if (w_str_path) begin
            n_mode = MODE_STR;
            if (i_byte != CH_BEL && !(w_esc_in && i_byte == CH_BSL)) begin
                n_st.esc = w_esc_in;
                if (i_byte == CH_ESC) begin
                    n_esc = 1'b1;
                end else begin
                    n_st.sbyte = 1'b1;
                    n_esc      = 1'b0;
                end
            end else begin
                n_st.esc = (i_byte == CH_BEL) && w_esc_in;
                n_esc    = 1'b0;
                v_tk     = 1'b1;
            end
        end else if (!w_num_path) begin
            if (w_digit) begin
                n_acc  = 16'(w_d);
                n_mode = MODE_NUM;
            end else begin
                v_tk      = 1'b1;
                v_tk_char = 1'b1;
            end
        end else begin
            if (w_digit) begin
                n_acc = w_sat;
            end else if (w_sep && w_el.hit) begin
                n_mode = MODE_LIST;
                v_push = 1'b1;
                n_acc  = '0;
            end else begin
                v_push = 1'b1;
                n_acc  = '0;
                if (w_e1.hit && !w_e1.fin) begin
                    n_trie    = w_e1.target;
                    n_mode    = MODE_NONE;
                    v_tk      = 1'b1;
                    v_tk_char = 1'b1;
                    v_edge    = w_e2;
                end else begin
                    v_tk = 1'b1;
                    v_ev = EV_REFEED;
                end
            end
        end

        v_fill = r_fill;
        v_ovf  = r_ovf;
        w_we   = 1'b0;
        if (v_push) begin
            if (r_fill < FW'(MAX_PARAMS)) begin
                w_we   = 1'b1;
                v_fill = r_fill + FW'(1);
            end else begin
                v_ovf = 1'b1;
            end
        end
        n_fill = v_fill;
        n_ovf  = v_ovf;
        v_h0   = v_tk_char ? i_byte : r_h0;
        v_h1   = v_tk_char ? r_h0 : r_h1;
        n_h0   = v_h0;
        n_h1   = v_h1;

        v_fill7 = 7'(v_fill);
        v_cap   = n_st.esc ? 7'(OUT_LIMIT - 1) : 7'(OUT_LIMIT);

        if (v_tk) begin
            if (!v_edge.hit || v_edge.fin) begin
                if (!v_edge.hit) begin
                    n_st.err = 1'b1;
                end else begin
                    n_st.acc     = 1'b1;
                    n_st.burst_n = (v_fill7 > v_cap) ? v_cap[4:0] : v_fill7[4:0];
                    n_p_ev       = v_ev;
                    n_p_rule     = v_edge.target;
                    n_p_fin      = v_h0;
                    n_p_mid      = v_h1;
                    n_p_count    = v_fill7[4:0];
                    n_p_ovf      = v_ovf;
                end
                // sequence done: back to the root
                n_trie = '0;
                n_mode = MODE_NONE;
                n_acc  = '0;
                n_fill = '0;
                n_ovf  = 1'b0;
                n_esc  = 1'b0;
                n_h0   = '0;
                n_h1   = '0;
            end else begin
                n_trie = v_edge.target;
                n_mode = MODE_NONE;
            end
        end
    end

    assign w_fill_ext = 7'(r_fill);
    assign w_ridx_ext = 7'(i_cmd.idx);

    esp_ram #(
        .W     (16),
        .DEPTH (MAX_PARAMS)
    ) u_param_ram (
        .i_clk   (i_clk),
        .i_we    (w_we && i_cmd.take),
        .i_waddr (w_fill_ext[AW-1:0]),
        .i_wdata (r_acc),
        .i_re    (i_cmd.rd),
        .i_raddr (w_ridx_ext[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trie <= '0;
            r_mode <= MODE_NONE;
            r_acc  <= '0;
            r_fill <= '0;
            r_ovf  <= 1'b0;
            r_esc  <= 1'b0;
            r_h0   <= '0;
            r_h1   <= '0;
            r_st   <= '0;
        end else if (i_cmd.take) begin
            r_trie <= n_trie;
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_fill <= n_fill;
            r_ovf  <= n_ovf;
            r_esc  <= n_esc;
            r_h0   <= n_h0;
            r_h1   <= n_h1;
            r_st   <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_p_ev    <= n_p_ev;
            r_p_rule  <= n_p_rule;
            r_p_fin   <= n_p_fin;
            r_p_mid   <= n_p_mid;
            r_p_count <= n_p_count;
            r_p_ovf   <= n_p_ovf;
            r_p_byte  <= i_byte;
        end
        if (i_cmd.ld != LD_NONE) begin
            r_o_ev   <= EV_STR;
            r_o_rule <= '0;
            r_o_fin  <= '0;
            r_o_mid  <= '0;
            r_o_idx  <= '0;
            r_o_val  <= '0;
            r_o_cnt  <= '0;
            r_o_ovf  <= 1'b0;
            r_o_sb   <= '0;
            r_o_last <= i_cmd.last;
            case (i_cmd.ld)
                LD_ESC:  r_o_sb <= CH_ESC;
                LD_BYTE: r_o_sb <= r_p_byte;
                LD_ERR:  r_o_ev <= EV_ERROR;
                LD_ACC, LD_PAR: begin
                    r_o_ev   <= r_p_ev;
                    r_o_rule <= r_p_rule[5:0];
                    r_o_fin  <= r_p_fin;
                    r_o_mid  <= r_p_mid;
                    r_o_ovf  <= r_p_ovf;
                    if (i_cmd.ld == LD_PAR) begin
                        r_o_idx <= i_cmd.idx;
                        r_o_val <= w_rdata;
                        r_o_cnt <= r_p_count;
                    end
                end
                default: r_o_sb <= '0;
            endcase
        end
    end

    assign o_status         = r_st;
    assign o_event_res      = r_o_ev;
    assign o_rule_id        = r_o_rule;
    assign o_final_char     = r_o_fin;
    assign o_middle_char    = r_o_mid;
    assign o_param_index    = r_o_idx;
    assign o_param_value    = r_o_val;
    assign o_param_count    = r_o_cnt;
    assign o_param_overflow = r_o_ovf;
    assign o_string_byte    = r_o_sb;
    assign o_last           = r_o_last;
endmodule

[rtl/core/esp_checker.sv]
// Port-level checks for the escape sequence parser, bound to the top level.
// Depends on esp_pkg and escape_sequence_parser_macros.svh.
`include "escape_sequence_parser_macros.svh"

module esp_checker
    import esp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    // one byte in flight: no input while a result is shown
    `ESP_ASSERT_NOW(a_no_overlap, s_axis_tready, !m_axis_tvalid)
    // an error is always the last result of its byte
    `ESP_ASSERT_NOW(a_err_last, m_axis_tvalid && m_axis_tuser == EV_ERROR, m_axis_tlast)
    // string results carry nothing but the byte
    `ESP_ASSERT_NOW(a_str_clean, m_axis_tvalid && m_axis_tuser == EV_STR, m_axis_tdata[47:0] == 48'd0)
    // a result transfer with tlast frees the input next
    `ESP_ASSERT_NEXT(a_last_frees, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
endmodule

bind escape_sequence_parser esp_checker u_esp_checker (.*);
